// ===== rtl/core/mcg_pkg.sv =====
`default_nettype none

package mcg_pkg;

    // Input opcodes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_LOAD_BEAT = 2'd1;
    localparam logic [1:0] OP_LOAD_BELL = 2'd2;
    localparam logic [1:0] OP_RESTART   = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_TEMPO       = 3'd0;
    localparam logic [2:0] REG_BEATS       = 3'd1;
    localparam logic [2:0] REG_RING_ENABLE = 3'd2;
    localparam logic [2:0] REG_BEAT_LENGTH = 3'd3;
    localparam logic [2:0] REG_RING_LENGTH = 3'd4;
    localparam logic [2:0] REG_RATE_RATIO  = 3'd5;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Samples per minute at 48 kHz
    localparam int SAMPLE_RATE    = 48000;
    localparam int SECS_PER_MIN   = 60;
    localparam int DIVIDEND_W     = 22;
    localparam logic [DIVIDEND_W-1:0] DIVIDEND = DIVIDEND_W'(SAMPLE_RATE * SECS_PER_MIN);
    localparam logic [4:0] DIV_LAST_BIT = 5'(DIVIDEND_W - 1);

    localparam logic [7:0]  TEMPO_MIN   = 8'd40;
    localparam logic [7:0]  TEMPO_MAX   = 8'd240;
    localparam logic [7:0]  TEMPO_RESET = 8'd60;
    localparam logic [16:0] SPB_RESET   = 17'(SAMPLE_RATE * SECS_PER_MIN / 60);
    localparam logic [3:0]  BEATS_RESET = 4'd4;

    localparam int POS_W      = 17;
    localparam int BELL_POS_W = 16;
    localparam int CMP_W      = 18;
    localparam logic [BELL_POS_W-1:0] BELL_POS_MAX = '1;

    // Soft mix divisor for the positive quadrant
    localparam logic [17:0] MIX_POS_DIV = 18'd32767;

    // Frame queue between front and back
    localparam int QDEPTH   = 8;
    localparam int QPTR_W   = 3;
    localparam int QCOUNT_W = 4;
    localparam int REP_W    = 5;

    typedef struct packed {
        logic [7:0]  tempo;
        logic [3:0]  beats_per_bar;
        logic        ring_enable;
        logic [13:0] beat_length;
        logic [15:0] ring_length;
        logic [3:0]  rate_ratio;
        logic [16:0] spb;
        logic [7:0]  remainder;
        logic        busy;
    } cfg_t;

    typedef struct packed {
        logic clr_frac;
        logic clr_bar;
    } cfg_evt_t;

    typedef struct packed {
        logic [15:0]      sample;
        logic             began;
        logic [3:0]       bar;
        logic [REP_W-1:0] reps;
    } frame_t;

endpackage

`default_nettype wire

// ===== rtl/core/mcg_regs.sv =====
`default_nettype none

module mcg_regs
    import mcg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output cfg_t                   cfg,
    output cfg_evt_t               evt
);

    logic [7:0]  tempo_reg;
    logic [3:0]  beats_reg;
    logic        ring_enable_reg;
    logic [13:0] beat_length_reg;
    logic [15:0] ring_length_reg;
    logic [3:0]  rate_ratio_reg;

    logic        div_busy_reg;
    logic [4:0]  div_cnt_reg;
    logic [8:0]  div_rem_reg;
    logic [16:0] div_quo_reg;

    logic       wr_en;
    logic [2:0] reg_index;
    logic [7:0] new_tempo;
    logic [3:0] new_beats;
    logic       tempo_load;
    logic       beats_change;
    logic [8:0] div_shift;
    logic       div_ge;

    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[4:2];
    assign new_tempo = pwdata[7:0];
    assign new_beats = pwdata[3:0];

    assign tempo_load = wr_en && (reg_index == REG_TEMPO) && (new_tempo >= TEMPO_MIN)
                        && (new_tempo <= TEMPO_MAX) && (new_tempo != tempo_reg);
    assign beats_change = wr_en && (reg_index == REG_BEATS) && (new_beats != beats_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg       <= TEMPO_RESET;
            beats_reg       <= BEATS_RESET;
            ring_enable_reg <= 1'b0;
            beat_length_reg <= '0;
            ring_length_reg <= '0;
            rate_ratio_reg  <= 4'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_TEMPO:
                begin
                    if (tempo_load)
                        tempo_reg <= new_tempo;
                end
                REG_BEATS:       beats_reg       <= new_beats;
                REG_RING_ENABLE: ring_enable_reg <= pwdata[0];
                REG_BEAT_LENGTH: beat_length_reg <= pwdata[13:0];
                REG_RING_LENGTH: ring_length_reg <= pwdata[15:0];
                REG_RATE_RATIO:  rate_ratio_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Restoring divider: one quotient bit per cycle, MSB of the dividend first
    assign div_shift = {div_rem_reg[7:0], DIVIDEND[div_cnt_reg]};
    assign div_ge    = div_shift >= {1'b0, tempo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_quo_reg  <= SPB_RESET;
        end
        else if (tempo_load)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= DIV_LAST_BIT;
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_ge ? (div_shift - {1'b0, tempo_reg}) : div_shift;
            div_quo_reg <= {div_quo_reg[15:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 5'd1;
            if (div_cnt_reg == 5'd0)
                div_busy_reg <= 1'b0;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_TEMPO:       prdata = 32'(tempo_reg);
            REG_BEATS:       prdata = 32'(beats_reg);
            REG_RING_ENABLE: prdata = 32'(ring_enable_reg);
            REG_BEAT_LENGTH: prdata = 32'(beat_length_reg);
            REG_RING_LENGTH: prdata = 32'(ring_length_reg);
            REG_RATE_RATIO:  prdata = 32'(rate_ratio_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.tempo         = tempo_reg;
    assign cfg.beats_per_bar = beats_reg;
    assign cfg.ring_enable   = ring_enable_reg;
    assign cfg.beat_length   = beat_length_reg;
    assign cfg.ring_length   = ring_length_reg;
    assign cfg.rate_ratio    = rate_ratio_reg;
    assign cfg.spb           = div_quo_reg;
    assign cfg.remainder     = div_rem_reg[7:0];
    assign cfg.busy          = div_busy_reg;

    assign evt.clr_frac = tempo_load;
    assign evt.clr_bar  = beats_change;

    a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tempo_reg >= TEMPO_MIN) && (tempo_reg <= TEMPO_MAX))
        else $error("tempo register out of range");

    a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        !div_busy_reg |-> (32'(div_quo_reg) * 32'(tempo_reg) + 32'(div_rem_reg)
                           == 32'(DIVIDEND)) && (div_rem_reg < {1'b0, tempo_reg}))
        else $error("beat length division result inconsistent");

endmodule

`default_nettype wire

// ===== rtl/core/mcg_front.sv =====
`default_nettype none

module mcg_front
    import mcg_pkg::*;
#(
    parameter int BEAT_DEPTH = 8192,
    parameter int BELL_DEPTH = 32768,
    parameter int MAX_REPEAT = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [14:0] load_address,
    input  wire logic [15:0] load_sample,
    input  wire cfg_t        cfg,
    input  wire cfg_evt_t    evt,
    output logic             push,
    output frame_t           push_frame,
    input  wire logic        pop
);

    localparam int BEAT_AW = $clog2(BEAT_DEPTH);
    localparam int BELL_AW = $clog2(BELL_DEPTH);
    localparam logic [CMP_W-1:0] BEAT_LIM = CMP_W'(BEAT_DEPTH);
    localparam logic [CMP_W-1:0] BELL_LIM = CMP_W'(BELL_DEPTH);
    localparam logic [REP_W-1:0] REP_MAX  = REP_W'(MAX_REPEAT);

    logic [15:0] beat_mem [BEAT_DEPTH];
    logic [15:0] bell_mem [BELL_DEPTH];

    logic [POS_W-1:0]      beat_position_reg;
    logic [3:0]            bar_count_reg;
    logic [8:0]            fraction_numerator_reg;
    logic                  extra_sample_reg;
    logic                  bell_active_reg;
    logic [BELL_POS_W-1:0] bell_position_reg;
    logic [QCOUNT_W-1:0]   credit_reg;

    logic                  s1_valid_reg;
    logic                  s1_beat_hit_reg;
    logic                  s1_bell_hit_reg;
    logic [15:0]           beat_rdata_reg;
    logic [15:0]           bell_rdata_reg;
    logic                  s1_began_reg;
    logic [3:0]            s1_bar_reg;
    logic [REP_W-1:0]      s1_reps_reg;

    logic                  s2_valid_reg;
    logic signed [15:0]    s2_a_reg;
    logic signed [15:0]    s2_b_reg;
    logic [31:0]           s2_prod_reg;
    logic                  s2_began_reg;
    logic [3:0]            s2_bar_reg;
    logic [REP_W-1:0]      s2_reps_reg;

    logic accept;
    logic is_tick;
    logic is_load_beat;
    logic is_load_bell;
    logic is_restart;

    logic [POS_W-1:0]      pos_inc;
    logic                  beat_end;
    logic [3:0]            bar_inc;
    logic                  bar_wrap;
    logic [3:0]            bar_after;
    logic [8:0]            frac_sum;
    logic                  frac_over;
    logic                  bell_start;
    logic                  bell_on;
    logic [BELL_POS_W-1:0] bell_cur;
    logic [BELL_POS_W-1:0] bell_inc;
    logic                  bell_stop;
    logic                  beat_hit;
    logic                  bell_hit;
    logic [REP_W-1:0]      ratio_ext;
    logic [REP_W-1:0]      reps;
    logic [CMP_W-1:0]      load_ext;
    logic [CMP_W-1:0]      beat_pos_ext;
    logic [CMP_W-1:0]      bell_pos_ext;
    logic                  beat_we;
    logic                  bell_we;

    logic signed [15:0]    s1_a;
    logic signed [15:0]    s1_b;
    logic [15:0]           abs_a;
    logic [15:0]           abs_b;

    logic signed [18:0]    mix_sum;
    logic [16:0]           q0;
    logic [17:0]           q_fix;
    logic [16:0]           q_pos;
    logic signed [18:0]    q_neg_s;
    logic signed [18:0]    q_pos_s;
    logic signed [18:0]    mix_res;

    assign in_stall = cfg.busy || (credit_reg == QCOUNT_W'(QDEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        is_tick      = 1'b0;
        is_load_beat = 1'b0;
        is_load_bell = 1'b0;
        is_restart   = 1'b0;
        unique case (opcode)
            OP_TICK:      is_tick      = accept;
            OP_LOAD_BEAT: is_load_beat = accept;
            OP_LOAD_BELL: is_load_bell = accept;
            OP_RESTART:   is_restart   = accept;
            default: ;
        endcase
    end

    // Beat and bar bookkeeping for one tick
    assign pos_inc   = beat_position_reg + POS_W'(1);
    assign beat_end  = pos_inc >= (cfg.spb + POS_W'(extra_sample_reg));
    assign bar_inc   = bar_count_reg + 4'd1;
    assign bar_wrap  = bar_inc == cfg.beats_per_bar;
    assign bar_after = beat_end ? (bar_wrap ? 4'd0 : bar_inc) : bar_count_reg;
    assign frac_sum  = fraction_numerator_reg + 9'(cfg.remainder);
    assign frac_over = frac_sum > 9'(cfg.tempo);

    assign bell_start = beat_end && bar_wrap && (cfg.beats_per_bar > 4'd1) && cfg.ring_enable;
    assign bell_on    = bell_start || bell_active_reg;
    assign bell_cur   = bell_start ? '0 : bell_position_reg;
    assign bell_inc   = (bell_cur != BELL_POS_MAX) ? (bell_cur + BELL_POS_W'(1)) : bell_cur;
    assign bell_stop  = bell_inc >= cfg.ring_length;

    assign beat_pos_ext = CMP_W'(beat_position_reg);
    assign bell_pos_ext = CMP_W'(bell_cur);
    assign load_ext     = CMP_W'(load_address);

    assign beat_hit = (beat_pos_ext < CMP_W'(cfg.beat_length)) && (beat_pos_ext < BEAT_LIM);
    assign bell_hit = bell_on && (bell_pos_ext < CMP_W'(cfg.ring_length))
                      && (bell_pos_ext < BELL_LIM);

    assign beat_we = is_load_beat && (load_ext < BEAT_LIM);
    assign bell_we = is_load_bell && (load_ext < BELL_LIM);

    assign ratio_ext = REP_W'(cfg.rate_ratio);
    assign reps = (ratio_ext == '0) ? REP_W'(1) : ((ratio_ext > REP_MAX) ? REP_MAX : ratio_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_position_reg      <= '0;
            bar_count_reg          <= '0;
            fraction_numerator_reg <= '0;
            extra_sample_reg       <= 1'b0;
            bell_active_reg        <= 1'b0;
            bell_position_reg      <= '0;
        end
        else
        begin
            if (is_tick)
            begin
                beat_position_reg <= beat_end ? '0 : pos_inc;
                bar_count_reg     <= bar_after;
                if (beat_end && (cfg.remainder != 8'd0))
                begin
                    extra_sample_reg       <= frac_over;
                    fraction_numerator_reg <= frac_over ? (frac_sum - 9'(cfg.tempo)) : frac_sum;
                end
                if (bell_on)
                begin
                    bell_position_reg <= bell_inc;
                    bell_active_reg   <= !bell_stop;
                end
            end
            if (is_restart)
            begin
                beat_position_reg      <= '0;
                bar_count_reg          <= '0;
                fraction_numerator_reg <= '0;
                extra_sample_reg       <= 1'b0;
            end
            if (evt.clr_frac)
            begin
                fraction_numerator_reg <= '0;
                extra_sample_reg       <= 1'b0;
            end
            if (evt.clr_bar)
                bar_count_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_we)
            beat_mem[load_ext[BEAT_AW-1:0]] <= load_sample;
        if (is_tick)
            beat_rdata_reg <= beat_mem[beat_pos_ext[BEAT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (bell_we)
            bell_mem[load_ext[BELL_AW-1:0]] <= load_sample;
        if (is_tick)
            bell_rdata_reg <= bell_mem[bell_pos_ext[BELL_AW-1:0]];
    end

    // Stage 1: sound words read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= is_tick;
    end

    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            s1_beat_hit_reg <= beat_hit;
            s1_bell_hit_reg <= bell_hit;
            s1_began_reg    <= beat_end;
            s1_bar_reg      <= bar_after;
            s1_reps_reg     <= reps;
        end
    end

    assign s1_a  = s1_beat_hit_reg ? signed'(beat_rdata_reg) : 16'sd0;
    assign s1_b  = s1_bell_hit_reg ? signed'(bell_rdata_reg) : 16'sd0;
    assign abs_a = s1_a[15] ? (~s1_a + 16'd1) : s1_a;
    assign abs_b = s1_b[15] ? (~s1_b + 16'd1) : s1_b;

    // Stage 2: magnitude product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_a_reg     <= s1_a;
            s2_b_reg     <= s1_b;
            s2_prod_reg  <= 32'(abs_a) * 32'(abs_b);
            s2_began_reg <= s1_began_reg;
            s2_bar_reg   <= s1_bar_reg;
            s2_reps_reg  <= s1_reps_reg;
        end
    end

    // Soft mix; p/32767 = q0 + one correction, since q0 + low bits stays under 2*32767
    assign mix_sum = 19'(s2_a_reg) + 19'(s2_b_reg);
    assign q0      = s2_prod_reg[31:15];
    assign q_fix   = 18'(q0) + 18'(s2_prod_reg[14:0]);
    assign q_pos   = q0 + 17'(q_fix >= MIX_POS_DIV);
    assign q_neg_s = signed'({2'b00, q0});
    assign q_pos_s = signed'({2'b00, q_pos});

    always_comb
    begin
        if (s2_a_reg[15] && s2_b_reg[15])
            mix_res = mix_sum + q_neg_s;
        else if ((s2_a_reg > 16'sd0) && (s2_b_reg > 16'sd0))
            mix_res = mix_sum - q_pos_s;
        else
            mix_res = mix_sum;
    end

    assign push              = s2_valid_reg;
    assign push_frame.sample = mix_res[15:0];
    assign push_frame.began  = s2_began_reg;
    assign push_frame.bar    = s2_bar_reg;
    assign push_frame.reps   = s2_reps_reg;

    // One queue slot is reserved per tick from acceptance until the back takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else if (is_tick && !pop)
            credit_reg <= credit_reg + QCOUNT_W'(1);
        else if (!is_tick && pop)
            credit_reg <= credit_reg - QCOUNT_W'(1);
    end

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= QCOUNT_W'(QDEPTH))
        else $error("queue credit overrun");

    a_push_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg || s1_valid_reg) |-> (credit_reg != '0))
        else $error("frame in flight without a reserved queue slot");

endmodule

`default_nettype wire

// ===== rtl/core/mcg_queue.sv =====
`default_nettype none

module mcg_queue
    import mcg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire frame_t push_frame,
    input  wire logic   pop,
    output logic        head_valid,
    output frame_t      head_frame
);

    frame_t              slots [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCOUNT_W'(1);
            else if (!push && pop)
                count_reg <= count_reg - QCOUNT_W'(1);
        end
    end

    assign head_valid = count_reg != '0;
    assign head_frame = slots[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCOUNT_W'(QDEPTH)))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("frame queue underflow");

endmodule

`default_nettype wire

// ===== rtl/core/mcg_back.sv =====
`default_nettype none

module mcg_back
    import mcg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   head_valid,
    input  wire frame_t head_frame,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [15:0] sample,
    output logic        beat_start,
    output logic [3:0]  beat_in_bar,
    output logic        last
);

    logic             out_valid_reg;
    logic             last_reg;
    logic [15:0]      sample_reg;
    logic             began_reg;
    logic [3:0]       bar_reg;
    logic [REP_W-1:0] reps_left_reg;
    logic             out_fire;

    assign out_fire = out_valid_reg && !out_stall;
    assign pop      = head_valid && (!out_valid_reg || (out_fire && last_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_fire && last_reg)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg    <= head_frame.sample;
            began_reg     <= head_frame.began;
            bar_reg       <= head_frame.bar;
            reps_left_reg <= head_frame.reps;
            last_reg      <= head_frame.reps == REP_W'(1);
        end
        else if (out_fire && !last_reg)
        begin
            reps_left_reg <= reps_left_reg - REP_W'(1);
            last_reg      <= reps_left_reg == REP_W'(2);
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign beat_start  = began_reg;
    assign beat_in_bar = bar_reg;
    assign last        = last_reg;

    a_repeat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |=> out_valid_reg)
        else $error("frame repetition dropped before its last copy");

endmodule

`default_nettype wire

// ===== rtl/core/metronome_click_generator_core.sv =====
`default_nettype none

// Metronome click generator, 48 kHz frame source.
// Input channel (in_valid / in_stall): each request carries an opcode.
//   Tick plays one frame; load-beat and load-bell write one word of the beat
//   or bell sound memory at load_address; restart clears the beat, bar and
//   fraction counters (a ringing bell keeps playing). Only ticks give output.
// Output channel (out_valid / out_stall): each tick yields rate_ratio copies
//   of its frame (sample, beat_start, beat_in_bar), last set on the final one.
// Configuration is to be written over the APB port while the block is idle;
//   the block does not enforce this. A tick passes the stage-1 and stage-2
//   registers, the frame queue and the output register. One request per cycle
//   while in_stall is low; the output drains one copy per cycle while out_stall
//   is low; rate_ratio 0 reads as 1 and is capped at MAX_REPEAT. A tempo write
//   runs a bit-serial divider for the beat length, holding in_stall high.
// When the receiver stalls, the output holds and the frame queue (8 entries)
//   fills; in_stall rises once every queue slot is reserved.
// Reset clears all counters, empties the queue and restores register
//   defaults; sound memories are not cleared and need loading before use.
module metronome_click_generator_core
    import mcg_pkg::*;
#(
    parameter int BEAT_DEPTH = 8192,
    parameter int BELL_DEPTH = 32768,
    parameter int MAX_REPEAT = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    input  wire logic [14:0]       load_address,
    input  wire logic [15:0]       load_sample,
    // Frame channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [15:0]            sample,
    output logic                   beat_start,
    output logic [3:0]             beat_in_bar,
    output logic                   last,
    // Configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    cfg_t     cfg;
    cfg_evt_t evt;
    logic     push;
    frame_t   push_frame;
    logic     pop;
    logic     head_valid;
    frame_t   head_frame;

    // Never wait-state the configuration bus
    assign pready = 1'b1;

    // Hold register values and derive samples per beat on tempo change
    mcg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .evt     (evt)
    );

    // Accept requests, advance the beat/bar/bell counters, read and mix samples
    mcg_front #(
        .BEAT_DEPTH (BEAT_DEPTH),
        .BELL_DEPTH (BELL_DEPTH),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .load_address (load_address),
        .load_sample  (load_sample),
        .cfg          (cfg),
        .evt          (evt),
        .push         (push),
        .push_frame   (push_frame),
        .pop          (pop)
    );

    // Decouple the mixing pipeline from the repeating output stage
    mcg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    // Drive each frame out once per repetition
    mcg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_frame  (head_frame),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .beat_start  (beat_start),
        .beat_in_bar (beat_in_bar),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

import mcg_pkg::*;

// One expected frame copy on the output channel.
typedef struct packed {
    logic [15:0] sample;
    logic        began;
    logic [3:0]  bar;
    logic        last;
} click_frame_t;

class frame_scoreboard;
    localparam int BEAT_WORDS = 8192;
    localparam int BELL_WORDS = 32768;
    localparam int MAX_REP    = 8;

    // register mirror
    logic [7:0]  bpm;
    logic [3:0]  meter;
    logic        ring_on;
    logic [13:0] beat_len;
    logic [15:0] ring_len;
    logic [3:0]  rep_reg;
    logic [16:0] beat_span;
    logic [7:0]  beat_rem;

    // playback state
    logic [16:0] beat_pos;
    logic [3:0]  bar;
    logic [8:0]  frac_num;
    logic        extra;
    logic        bell_on;
    logic [15:0] bell_pos;
    logic [15:0] beat_mem [BEAT_WORDS];
    logic [15:0] bell_mem [BELL_WORDS];

    click_frame_t frames_due [$];
    int           errors;

    function new();
        bpm      = TEMPO_RESET;
        set_beat_rate(TEMPO_RESET);
        meter    = BEATS_RESET;
        ring_on  = 1'b0;
        beat_len = '0;
        ring_len = '0;
        rep_reg  = 4'd1;
        beat_pos = '0;
        bar      = '0;
        bell_on  = 1'b0;
        bell_pos = '0;
        errors   = 0;
    endfunction

    function void set_beat_rate(logic [7:0] t);
        int unsigned q;
        q         = (SAMPLE_RATE * SECS_PER_MIN) / t;
        bpm       = t;
        beat_span = q[16:0];
        beat_rem  = 8'((SAMPLE_RATE * SECS_PER_MIN) - q * t);
        frac_num  = '0;
        extra     = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_TEMPO:
                if (val[7:0] >= TEMPO_MIN && val[7:0] <= TEMPO_MAX && val[7:0] != bpm)
                    set_beat_rate(val[7:0]);
            REG_BEATS:
                if (val[3:0] != meter)
                begin
                    meter = val[3:0];
                    bar   = '0;
                end
            REG_RING_ENABLE: ring_on  = val[0];
            REG_BEAT_LENGTH: beat_len = val[13:0];
            REG_RING_LENGTH: ring_len = val[15:0];
            REG_RATE_RATIO:  rep_reg  = val[3:0];
            default: ;
        endcase
    endfunction

    function int soft_mix(int a, int b);
        int p;
        p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        if (a < 0 && b < 0)
            return a + b + p / 32768;
        if (a > 0 && b > 0)
            return a + b - p / 32767;
        return a + b;
    endfunction

    // Advance one frame and queue its copies.
    function void play_tick();
        int           blen;
        int           rlen;
        int           s;
        int           b;
        int           reps;
        logic         began;
        click_frame_t f;
        blen  = (beat_len < BEAT_WORDS) ? beat_len : BEAT_WORDS;
        rlen  = (ring_len < BELL_WORDS) ? ring_len : BELL_WORDS;
        began = 1'b0;
        s     = 0;
        if (beat_pos < blen)
            s = int'($signed(beat_mem[beat_pos]));
        beat_pos = beat_pos + 1'b1;
        if (beat_pos >= beat_span + extra)
        begin
            began    = 1'b1;
            beat_pos = '0;
            bar      = bar + 1'b1;
            if (beat_rem != 0)
            begin
                frac_num = frac_num + beat_rem;
                if (frac_num > bpm)
                begin
                    extra    = 1'b1;
                    frac_num = frac_num - bpm;
                end
                else
                    extra = 1'b0;
            end
            if (bar == meter)
            begin
                if (meter > 1 && ring_on)
                begin
                    bell_pos = '0;
                    bell_on  = 1'b1;
                end
                bar = '0;
            end
        end
        if (bell_on)
        begin
            b = 0;
            if (bell_pos < rlen)
                b = int'($signed(bell_mem[bell_pos]));
            if (bell_pos != 16'hFFFF)
                bell_pos = bell_pos + 1'b1;
            s = (s != 0) ? soft_mix(s, b) : b;
            if (bell_pos >= ring_len)
                bell_on = 1'b0;
        end
        reps = (rep_reg == 0) ? 1 : ((rep_reg > MAX_REP) ? MAX_REP : rep_reg);
        for (int r = 0; r < reps; r++)
        begin
            f.sample = s[15:0];
            f.began  = began;
            f.bar    = bar;
            f.last   = (r == reps - 1);
            frames_due.push_back(f);
        end
    endfunction

    function void take_request(logic [1:0] op, logic [14:0] addr, logic [15:0] word);
        case (op)
            OP_LOAD_BEAT:
                if (addr < BEAT_WORDS)
                    beat_mem[addr] = word;
            // every 15-bit address lands inside the bell memory
            OP_LOAD_BELL: bell_mem[addr] = word;
            OP_RESTART:
            begin
                beat_pos = '0;
                bar      = '0;
                frac_num = '0;
                extra    = 1'b0;
            end
            default: play_tick();
        endcase
    endfunction

    task report_miss(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task match_frame(logic [15:0] sample, logic began, logic [3:0] bar_idx, logic last);
        click_frame_t want;
        if (frames_due.size() == 0)
        begin
            report_miss($sformatf("unexpected frame %h/%b/%0d/%b", sample, began,
                                  bar_idx, last));
            return;
        end
        want = frames_due.pop_front();
        if (sample !== want.sample || began !== want.began || bar_idx !== want.bar ||
            last !== want.last)
            report_miss($sformatf("got %h/%b/%0d/%b want %h/%b/%0d/%b", sample, began,
                                  bar_idx, last, want.sample, want.began, want.bar,
                                  want.last));
    endtask
endclass

module tb;
    localparam int          SETTLE_CYCLES = 30;      // output latency plus tempo divider
    localparam int          HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int unsigned CYCLE_LIMIT   = 100000;
    localparam int          BEAT_FILL     = 32;      // preloaded words at the beat start

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode       = OP_TICK;
    logic [14:0]       load_address = '0;
    logic [15:0]       load_sample  = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [15:0]       sample;
    logic              beat_start;
    logic [3:0]        beat_in_bar;
    logic              last;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    frame_scoreboard board;

    // Idle rates in percent, set by the stimulus for each phase.
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;

    // A toggle of hold_tog asks the receiver for one long hold-off.
    logic        hold_tog     = 1'b0;
    logic        hold_seen    = 1'b0;
    int          hold_left    = 0;
    int unsigned cycle_count  = 0;

    metronome_click_generator_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .load_address (load_address),
        .load_sample  (load_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .beat_start   (beat_start),
        .beat_in_bar  (beat_in_bar),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: honor a requested hold-off first, else stall at the phase's rate.
    always @(posedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Check every frame copy taken by the receiver.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.match_frame(sample, beat_start, beat_in_bar, last);
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // Offer one request and hold it until the block takes it.
    // Valid stays high into the next request unless the sender idles.
    task automatic send_req(input logic [1:0] op, input logic [14:0] addr,
                            input logic [15:0] word);
        // idle each cycle at the phase's rate before offering the request
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        load_address <= addr;
        load_sample  <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_request(op, addr, word);
    endtask

    // Drop valid, wait for every expected frame, then let the pipeline and
    // the tempo divider go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register over APB: setup cycle, then access cycle.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // Write all six registers; tempo goes last since it starts the divider.
    task automatic apply_setting(input logic [31:0] beats, input logic [31:0] ring,
                                 input logic [31:0] blen, input logic [31:0] rlen,
                                 input logic [31:0] rate, input logic [31:0] bpm);
        reg_write(REG_BEATS, beats);
        reg_write(REG_RING_ENABLE, ring);
        reg_write(REG_BEAT_LENGTH, blen);
        reg_write(REG_RING_LENGTH, rlen);
        reg_write(REG_RATE_RATIO, rate);
        reg_write(REG_TEMPO, bpm);
    endtask

    // Random register values; unused upper bits of pwdata are random too.
    task automatic random_setting();
        logic [31:0] bpm;
        logic [31:0] blen;
        bpm = $urandom;
        if ($urandom_range(99) < 80)
            bpm[7:0] = 8'($urandom_range(TEMPO_MIN, TEMPO_MAX));
        // keep beat reads inside the preloaded start of the beat memory
        blen = $urandom;
        blen[13:0] = 14'($urandom_range(BEAT_FILL));
        apply_setting($urandom, $urandom, blen, $urandom, $urandom, bpm);
    endtask

    // Mixed traffic: mostly ticks, some loads and restarts.
    task automatic random_burst(input int n);
        int          k;
        int unsigned pick;
        logic [14:0] addr;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_req(OP_TICK, 15'($urandom), 16'($urandom));
            else if (pick < 82)
            begin
                addr = 15'($urandom);
                // keep at least half of the beat loads inside the beat memory
                if ($urandom_range(1) == 1)
                    addr[14:13] = 2'b00;
                send_req(OP_LOAD_BEAT, addr, 16'($urandom));
            end
            else if (pick < 94)
                send_req(OP_LOAD_BELL, 15'($urandom), 16'($urandom));
            else
                send_req(OP_RESTART, 15'($urandom), 16'($urandom));
        end
    endtask

    task automatic play_ticks(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_req(OP_TICK, 15'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int i;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Preload the start of the beat memory; every beat read stays inside it.
        for (i = 0; i < BEAT_FILL; i++)
            send_req(OP_LOAD_BEAT, i[14:0], 16'($urandom));

        // Directed: repeat count 0 acts as 1, unchanged tempo is ignored.
        apply_setting(4, 0, 4, 0, 0, 32'(TEMPO_RESET));
        send_req(OP_LOAD_BEAT, 15'd0, 16'h8000);
        send_req(OP_LOAD_BEAT, 15'd1, 16'h7FFF);
        send_req(OP_LOAD_BEAT, 15'd2, 16'h0000);
        send_req(OP_LOAD_BEAT, 15'd3, 16'hFFFF);
        send_req(OP_LOAD_BEAT, 15'd8191, 16'h7FFF);
        send_req(OP_LOAD_BEAT, 15'd8192, 16'h1234);     // past the beat memory
        send_req(OP_LOAD_BEAT, 15'd32767, 16'h5555);    // past the beat memory
        send_req(OP_LOAD_BELL, 15'd0, 16'h7FFF);
        send_req(OP_LOAD_BELL, 15'd32767, 16'h8000);
        send_req(OP_RESTART, 15'd0, 16'h0000);
        play_ticks(6);                                  // runs past beat_length

        // Directed: out-of-range tempo writes are dropped, repeat count clamps.
        reg_write(REG_TEMPO, 32'd39);
        reg_write(REG_TEMPO, 32'd241);
        reg_write(REG_TEMPO, 32'hFFFF_FFFF);
        apply_setting(32'hFFFF_FFF0, 1, 8192, 65535, 15, 32'(TEMPO_MIN));
        send_req(OP_TICK, 15'h7FFF, 16'hFFFF);
        send_req(OP_RESTART, 15'h7FFF, 16'hFFFF);
        play_ticks(3);

        // Random: sender idles a little, receiver a lot.
        tx_idle_pct  = 10;
        rx_stall_pct = 52;
        random_setting();
        // Hold the receiver off while ticks keep coming so the queue fills.
        hold_tog <= ~hold_tog;
        play_ticks(40);
        random_burst(30);
        settle();   // pause the sender until every frame is back
        random_burst(15);
        random_setting();
        random_burst(30);

        // Random: sender idles a lot, receiver a little.
        tx_idle_pct  = 52;
        rx_stall_pct = 10;
        random_setting();
        random_burst(40);
        random_setting();
        random_burst(40);

        // Random: no idling at all.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        random_setting();
        random_burst(40);
        random_setting();
        random_burst(40);

        // Drain and give late frames a chance to show up.
        in_valid <= 1'b0;
        while (board.frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

`default_nettype wire

// ===== metronome_click_generator_core.f =====
rtl/core/mcg_pkg.sv
rtl/core/mcg_regs.sv
rtl/core/mcg_front.sv
rtl/core/mcg_queue.sv
rtl/core/mcg_back.sv
rtl/core/metronome_click_generator_core.sv
tb/tb.sv
